/* hw/rtl/assert_macros.svh */
// Assertion macros for the concurrent checks of the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and silenced while arst_n is low.
`define ASSERT_IMP(name, pre, con, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (con)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and silenced while arst_n is low.
`define ASSERT_NXT(name, pre, con, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (con)) \
		else $error(msg);

`endif

/* hw/rtl/bffa_pkg.sv */
// Types and constants shared by the bitmap first-fit allocator modules.
package bffa_pkg;

	localparam int WORD_W  = 64;
	localparam int WORD_SH = 6;
	localparam int CNT_W   = 13;
	localparam int IDX_W   = 12;
	localparam int CMD_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int BIDX_W  = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_INIT  = 2'd1;

	localparam logic [CNT_W-1:0] POOL_LIMIT_RST = 13'd4096;
	localparam logic [CNT_W-1:0] FREE_INIT_RST  = 13'd4096;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_LOAD  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic    clear;
		logic    latch;
		logic    scan_start;
		logic    scan_next;
		logic    alloc_commit;
		logic    rmw_read;
		logic    rmw_write;
		logic    res_set;
		status_t res_status;
	} bffa_cmd_t;

	typedef struct packed {
		logic clr_last;
		op_t  op;
		logic cnt_zero;
		logic no_words;
		logic free_oor;
		logic load_oor;
		logic found;
		logic scan_last;
	} bffa_stat_t;

endpackage

/* hw/rtl/bffa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module bffa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/bffa_ctrl.sv */
// Sequencer for the allocator: clearing pass, command decode, scan and read-modify-write.
module bffa_ctrl import bffa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  bffa_stat_t stat,
	output bffa_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MODIFY,
		S_REPORT
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_status = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_ALLOC: begin
						priority if (stat.cnt_zero) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_ZERO;
							state_d        = S_REPORT;
						end else if (stat.no_words) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_REPORT;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					OP_FREE: begin
						if (stat.free_oor) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_RANGE;
							state_d        = S_REPORT;
						end else begin
							cmd.rmw_read = 1'b1;
							state_d      = S_MODIFY;
						end
					end
					OP_LOAD: begin
						if (stat.load_oor) begin
							cmd.res_set = 1'b1;
							state_d     = S_REPORT;
						end else begin
							cmd.rmw_read = 1'b1;
							state_d      = S_MODIFY;
						end
					end
					OP_NONE: begin
						cmd.res_set = 1'b1;
						state_d     = S_REPORT;
					end
				endcase
			end
			S_SCAN: begin
				priority if (stat.found) begin
					cmd.alloc_commit = 1'b1;
					state_d          = S_REPORT;
				end else if (stat.scan_last) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_FULL;
					state_d        = S_REPORT;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_MODIFY: begin
				cmd.rmw_write = 1'b1;
				cmd.res_set   = 1'b1;
				state_d       = S_REPORT;
			end
			S_REPORT: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_d == S_REPORT);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

/* hw/rtl/bffa_dpath.sv */
// Datapath: bitmap memory, free counter, scan logic and result registers.
module bffa_dpath import bffa_pkg::*; #(
	parameter int POOL_BITS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bffa_cmd_t            cmd,
	output bffa_stat_t           stat,
	input  logic [CMD_W-1:0]     command,
	input  logic [IDX_W-1:0]     bit_index,
	input  logic [BIDX_W-1:0]    byte_index,
	input  logic [BYTE_W-1:0]    byte_value,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output logic [1:0]           status,
	output logic [IDX_W-1:0]     allocated_index,
	output logic [CNT_W-1:0]     free_count
);

	localparam int DEPTH     = (POOL_BITS + WORD_W - 1) / WORD_W;
	localparam int ADDR_W    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int LAST_BITS = POOL_BITS - (DEPTH - 1) * WORD_W;
	localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
	localparam int WCNT_W    = CNT_W - WORD_SH + 1;

	// Latched command word.
	op_t               op_q;
	logic [IDX_W-1:0]  bit_index_q;
	logic [BIDX_W-1:0] byte_index_q;
	logic [BYTE_W-1:0] byte_value_q;

	logic [CNT_W-1:0]  pool_limit_q;
	logic [CNT_W-1:0]  counter_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] scan_addr_q;
	status_t           status_q;
	logic [IDX_W-1:0]  idx_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic [CNT_W-1:0]   lim;
	logic [WCNT_W-1:0]  lim_words;
	logic [WCNT_W-1:0]  last_word;
	logic [WORD_SH-1:0] lim_rem;
	logic               scan_last;
	logic [WORD_W-1:0]  scan_mask;
	logic [WORD_W-1:0]  free_bits;
	logic [WORD_W-1:0]  iso;
	logic [WORD_SH-1:0] pos;

	logic [ADDR_W-1:0] rmw_addr;
	logic [WORD_W-1:0] load_mask;
	logic [WORD_W-1:0] merged;

	bffa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Scan covers entries below the smaller of the pool limit and the pool size.
	always_comb begin
		lim       = (32'(pool_limit_q) < POOL_BITS) ? pool_limit_q : CNT_W'(POOL_BITS);
		lim_rem   = lim[WORD_SH-1:0];
		lim_words = WCNT_W'(lim[CNT_W-1:WORD_SH]) + WCNT_W'(|lim_rem);
		last_word = lim_words - WCNT_W'(1);
		scan_last = (32'(scan_addr_q) == 32'(last_word));
		scan_mask = (scan_last && (lim_rem != '0)) ?
			({WORD_W{1'b1}} >> (WORD_W - 32'(lim_rem))) : {WORD_W{1'b1}};
		free_bits = ~ram_rdata & scan_mask;
		iso       = free_bits & (~free_bits + WORD_W'(1));
		pos       = '0;
		for (int j = 0; j < WORD_W; j++) begin
			if (iso[j]) begin
				pos = pos | WORD_SH'(j);
			end
		end
	end

	always_comb begin
		if (op_q == OP_FREE) begin
			rmw_addr = ADDR_W'(bit_index_q >> WORD_SH);
		end else begin
			rmw_addr = ADDR_W'(byte_index_q >> 3);
		end
		load_mask = (32'(rmw_addr) == DEPTH - 1) ? LAST_MASK : {WORD_W{1'b1}};
		if (op_q == OP_FREE) begin
			merged = ram_rdata & ~(WORD_W'(1) << bit_index_q[WORD_SH-1:0]);
		end else begin
			merged = ram_rdata;
			for (int j = 0; j < WORD_W; j++) begin
				if ((3'(j >> 3) == byte_index_q[2:0]) && load_mask[j]) begin
					merged[j] = byte_value_q[j & 7];
				end
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		ram_raddr = '0;
		priority if (cmd.clear) begin
			ram_we = 1'b1;
		end else if (cmd.alloc_commit) begin
			ram_we    = 1'b1;
			ram_waddr = scan_addr_q;
			ram_wdata = ram_rdata | iso;
		end else if (cmd.rmw_write) begin
			ram_we    = 1'b1;
			ram_waddr = rmw_addr;
			ram_wdata = merged;
		end
		priority if (cmd.scan_next) begin
			ram_raddr = scan_addr_q + ADDR_W'(1);
		end else if (cmd.rmw_read) begin
			ram_raddr = rmw_addr;
		end
	end

	always_comb begin
		stat.clr_last  = (32'(clr_addr_q) == DEPTH - 1);
		stat.op        = op_q;
		stat.cnt_zero  = (counter_q == '0);
		stat.no_words  = (lim == '0);
		stat.free_oor  = (32'(bit_index_q) >= 32'(pool_limit_q)) ||
			(32'(bit_index_q) >= POOL_BITS);
		stat.load_oor  = (32'(byte_index_q >> 3) >= DEPTH);
		stat.found     = |free_bits;
		stat.scan_last = scan_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_NONE;
			pool_limit_q <= POOL_LIMIT_RST;
			counter_q    <= FREE_INIT_RST;
			clr_addr_q   <= '0;
			scan_addr_q  <= '0;
		end else begin
			if (cmd.latch) begin
				op_q <= op_t'(command);
			end
			if (cmd.clear && !stat.clr_last) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cmd.scan_start) begin
				scan_addr_q <= '0;
			end else if (cmd.scan_next) begin
				scan_addr_q <= scan_addr_q + ADDR_W'(1);
			end
			if (cmd.alloc_commit) begin
				counter_q <= counter_q - CNT_W'(1);
			end else if (cmd.rmw_write && (op_q == OP_FREE) && (counter_q < pool_limit_q)) begin
				counter_q <= counter_q + CNT_W'(1);
			end
			if (cfg_we) begin
				if (cfg_index == CFG_POOL_LIMIT) begin
					pool_limit_q <= cfg_data;
				end
				if (cfg_index == CFG_FREE_INIT) begin
					counter_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			bit_index_q  <= bit_index;
			byte_index_q <= byte_index;
			byte_value_q <= byte_value;
		end
		if (cmd.alloc_commit) begin
			status_q <= ST_OK;
			idx_q    <= IDX_W'((32'(scan_addr_q) << WORD_SH) | 32'(pos));
		end else if (cmd.res_set) begin
			status_q <= cmd.res_status;
			idx_q    <= '0;
		end
	end

	assign status          = status_q;
	assign allocated_index = idx_q;
	assign free_count      = counter_q;

endmodule

/* hw/rtl/bitmap_first_fit_allocator.sv */
// Top level of the bitmap first-fit allocator: sequencer, datapath and checks.
//
//   channel   handshake                 word
//   command   start / busy              command, bit_index, byte_index, byte_value
//   result    done (one-cycle strobe)   status, allocated_index, free_count
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Allocate reads 64-bit bitmap words in order, at most ceil(min(pool limit, POOL_BITS) / 64),
// and raises done once a word with a free bit or the last word is read; the next word is taken
// in idle, after done. Free and load raise done after reading and writing one bitmap word;
// a command settled at decode (counter zero, empty scan range, free out of range, load beyond
// the pool, unused) raises it after decode. After reset a clearing pass writes every bitmap
// word, ceil(POOL_BITS / 64) in all (64 by default), with busy high; the receiver cannot stall.
`include "assert_macros.svh"

module bitmap_first_fit_allocator import bffa_pkg::*; #(
	parameter int POOL_BITS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [IDX_W-1:0]     bit_index,
	input  logic [BIDX_W-1:0]    byte_index,
	input  logic [BYTE_W-1:0]    byte_value,
	output logic                 done,
	output logic [1:0]           status,
	output logic [IDX_W-1:0]     allocated_index,
	output logic [CNT_W-1:0]     free_count,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	bffa_cmd_t  cmd;
	bffa_stat_t stat;

	assign cfg_ready = 1'b1;

	bffa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	bffa_dpath #(
		.POOL_BITS(POOL_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.command        (command),
		.bit_index      (bit_index),
		.byte_index     (byte_index),
		.byte_value     (byte_value),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.status         (status),
		.allocated_index(allocated_index),
		.free_count     (free_count)
	);

	`ASSERT_IMP(a_done_busy, done, busy, "done raised while not busy")
	`ASSERT_NXT(a_done_pulse, done, !done, "done held for more than one cycle")
	`ASSERT_NXT(a_accept_busy, start && !busy, busy && !done, "accepted word did not raise busy")
	`ASSERT_IMP(a_idx_zero, done && (status != ST_OK), allocated_index == '0,
		"failed command returned a nonzero index")

endmodule
